/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the I2C master bit engine
// Command codes, one tick's input item, result item and sequencer state.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
	localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_data;
		logic       send_ack;
		logic       sda_in;
		logic       scl_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_data;
		logic       ack_received;
		logic       rejected;
	} res_t;

	typedef struct packed {
		logic        scl;
		logic        sda;
		logic [15:0] wait_cnt;
		logic [2:0]  step;
		cmd_t        cmd;
		logic [3:0]  bit_cnt;
		logic [7:0]  shift_byte;
		logic        ack_choice;
		logic [7:0]  rx_byte;
		logic        ack_flag;
		logic        stretching;
	} state_t;

	localparam state_t STATE_RST = '{
		scl:        1'b1,
		sda:        1'b1,
		wait_cnt:   16'd0,
		step:       3'd0,
		cmd:        CMD_NONE,
		bit_cnt:    4'd0,
		shift_byte: 8'd0,
		ack_choice: 1'b0,
		rx_byte:    8'd0,
		ack_flag:   1'b0,
		stretching: 1'b0
	};

endpackage

/* rtl/i2cm_in_if.sv */
// ----------------------------------------------------------------------------
// i2cm_in_if: input item channel
// Valid/ready channel carrying one tick's command and pin samples.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] tx_data;
	logic       send_ack;
	logic       sda_in;
	logic       scl_in;

	modport source (output valid, func, tx_data, send_ack, sda_in, scl_in, input ready);
	modport sink   (input valid, func, tx_data, send_ack, sda_in, scl_in, output ready);
endinterface

/* rtl/i2cm_out_if.sv */
// ----------------------------------------------------------------------------
// i2cm_out_if: result item channel
// Valid/ready channel carrying line drives and status for one tick.
// ----------------------------------------------------------------------------
interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_data;
	logic       ack_received;
	logic       rejected;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_data,
		ack_received, rejected, input ready);
	modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_data,
		ack_received, rejected, output ready);
endinterface

/* rtl/i2cm_cfg_if.sv */
// ----------------------------------------------------------------------------
// i2cm_cfg_if: configuration write channel
// Valid/ready channel carrying the half period register value.
// ----------------------------------------------------------------------------
interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* rtl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: open-drain I2C master byte engine
// One transaction in per clock tick, one result transaction out per tick, while res.ready allows.
// ----------------------------------------------------------------------------
// Pipeline: each input transaction passes through the input register, then the
//   result register, before its result appears on the output channel.
// Throughput: one transaction per cycle unless res.ready stalls it; the sequencer
//   step is a single pass of short logic between the input and result registers.
// Reset: arst_n clears the pipeline, releases SCL and SDA, idles the
//   sequencer and loads half_period with 50.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
	input logic       clk,
	input logic       arst_n,
	i2cm_in_if.sink   cmd,
	i2cm_out_if.source res,
	i2cm_cfg_if.sink  cfg
);

	// input register stage
	i2cm_pkg::item_t  item_s1;
	logic             vld_s1;

	// result register stage
	i2cm_pkg::res_t   res_s2;
	logic             vld_s2;

	// engine state and configuration
	i2cm_pkg::state_t state_q;
	i2cm_pkg::state_t state_d;
	i2cm_pkg::res_t   res_d;
	logic [15:0]      half_period_q;

	logic             advance;

	// s1 moves into s2 whenever s2 is empty or being drained this cycle
	assign advance   = vld_s1 && (!vld_s2 || res.ready);
	assign cmd.ready = !vld_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cm_pkg::HALF_PERIOD_RST;
		end else if (cfg.valid) begin
			half_period_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.func     <= cmd.func;
			item_s1.tx_data  <= cmd.tx_data;
			item_s1.send_ack <= cmd.send_ack;
			item_s1.sda_in   <= cmd.sda_in;
			item_s1.scl_in   <= cmd.scl_in;
		end
	end

	i2cm_seq u_seq (
		.cur         (state_q),
		.item        (item_s1),
		.half_period (half_period_q),
		.nxt         (state_d),
		.res         (res_d)
	);

	// the state moves exactly once per transaction handed to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cm_pkg::STATE_RST;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (res.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign res.valid        = vld_s2;
	assign res.scl_out      = res_s2.scl_out;
	assign res.sda_out      = res_s2.sda_out;
	assign res.busy_res     = res_s2.busy_res;
	assign res.done_res     = res_s2.done_res;
	assign res.rx_data      = res_s2.rx_data;
	assign res.ack_received = res_s2.ack_received;
	assign res.rejected     = res_s2.rejected;

	// a finishing tick leaves the sequencer idle
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.done_res) |=> (state_q.cmd == i2cm_pkg::CMD_NONE))
		else $error("sequencer still active after done");

	// idle sequencer sits at the first step with no bits counted
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.cmd == i2cm_pkg::CMD_NONE) |-> (state_q.step == 3'd0 && state_q.bit_cnt == 4'd0))
		else $error("idle sequencer holds stale step or bit count");

	// never more than one byte's worth of bits
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_cnt <= i2cm_pkg::BITS_PER_BYTE)
		else $error("bit count overran a byte");

	// state only moves with a transaction through the pipeline
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a transaction");

	// a rejection only happens while a command is running
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.rejected) |-> (state_q.cmd != i2cm_pkg::CMD_NONE))
		else $error("command rejected while idle");

endmodule

/* rtl/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// i2cm_seq: one-tick sequencer step
// Next state and result for one input tick; purely combinational.
// ----------------------------------------------------------------------------
module i2cm_seq (
	input  i2cm_pkg::state_t cur,
	input  i2cm_pkg::item_t  item,
	input  logic [15:0]      half_period,
	output i2cm_pkg::state_t nxt,
	output i2cm_pkg::res_t   res
);

	logic [15:0] hold;
	logic        is_cmd;
	logic        run;
	logic        fin;
	logic        chg_sda;
	logic        chg_scl;
	logic        line_val;
	logic        rej;
	logic        stretch_on;
	logic [3:0]  bit_inc;

	assign hold   = (half_period == 16'd0) ? 16'd1 : half_period;
	assign is_cmd = (item.func >= i2cm_pkg::CMD_START) && (item.func <= i2cm_pkg::CMD_READ);

	always_comb begin
		nxt        = cur;
		rej        = 1'b0;
		run        = 1'b0;
		fin        = 1'b0;
		chg_sda    = 1'b0;
		chg_scl    = 1'b0;
		line_val   = 1'b0;
		stretch_on = 1'b0;
		bit_inc    = cur.bit_cnt + 4'd1;

		if (cur.cmd != i2cm_pkg::CMD_NONE) begin
			rej            = is_cmd;
			stretch_on     = cur.stretching && !item.scl_in;
			nxt.stretching = stretch_on;
			if (!stretch_on) begin
				if (cur.wait_cnt > 16'd1) begin
					nxt.wait_cnt = cur.wait_cnt - 16'd1;
				end else begin
					run = 1'b1;
				end
			end
		end else if (is_cmd) begin
			nxt.cmd        = i2cm_pkg::cmd_t'(item.func);
			nxt.step       = 3'd0;
			nxt.bit_cnt    = 4'd0;
			nxt.shift_byte = (item.func == i2cm_pkg::CMD_WRITE) ? item.tx_data : 8'd0;
			nxt.ack_choice = item.send_ack;
			bit_inc        = 4'd1;
			run            = 1'b1;
		end

		if (run) begin
			unique case (nxt.cmd)
				i2cm_pkg::CMD_START: begin
					unique case (nxt.step)
						3'd0: begin chg_sda = 1'b1; line_val = 1'b1; end
						3'd1: begin chg_scl = 1'b1; line_val = 1'b1; end
						3'd2: begin chg_sda = 1'b1; line_val = 1'b0; end
						3'd3: begin chg_scl = 1'b1; line_val = 1'b0; end
						default: fin = 1'b1;
					endcase
					if (!fin) nxt.step = nxt.step + 3'd1;
				end
				i2cm_pkg::CMD_STOP: begin
					unique case (nxt.step)
						3'd0: begin chg_scl = 1'b1; line_val = 1'b0; end
						3'd1: begin chg_sda = 1'b1; line_val = 1'b0; end
						3'd2: begin chg_scl = 1'b1; line_val = 1'b1; end
						3'd3: begin chg_sda = 1'b1; line_val = 1'b1; end
						default: fin = 1'b1;
					endcase
					if (!fin) nxt.step = nxt.step + 3'd1;
				end
				i2cm_pkg::CMD_WRITE: begin
					unique case (nxt.step)
						3'd0: begin
							chg_sda  = 1'b1;
							line_val = nxt.shift_byte[7];
							nxt.step = 3'd1;
						end
						3'd1: begin chg_scl = 1'b1; line_val = 1'b1; nxt.step = 3'd2; end
						3'd2: begin
							chg_scl        = 1'b1;
							line_val       = 1'b0;
							nxt.shift_byte = {nxt.shift_byte[6:0], 1'b0};
							nxt.bit_cnt    = bit_inc;
							nxt.step       = (bit_inc < i2cm_pkg::BITS_PER_BYTE) ? 3'd0 : 3'd3;
						end
						3'd3: begin chg_sda = 1'b1; line_val = 1'b1; nxt.step = 3'd4; end
						3'd4: begin chg_scl = 1'b1; line_val = 1'b1; nxt.step = 3'd5; end
						3'd5: begin
							nxt.ack_flag = !item.sda_in;
							chg_scl      = 1'b1;
							line_val     = 1'b0;
							nxt.step     = 3'd6;
						end
						3'd6: begin chg_sda = 1'b1; line_val = 1'b0; nxt.step = 3'd7; end
						default: fin = 1'b1;
					endcase
				end
				i2cm_pkg::CMD_READ: begin
					unique case (nxt.step)
						3'd0: begin chg_sda = 1'b1; line_val = 1'b1; nxt.step = 3'd1; end
						3'd1: begin chg_scl = 1'b1; line_val = 1'b1; nxt.step = 3'd2; end
						3'd2: begin
							nxt.shift_byte = {nxt.shift_byte[6:0], item.sda_in};
							chg_scl        = 1'b1;
							line_val       = 1'b0;
							nxt.bit_cnt    = bit_inc;
							nxt.step       = (bit_inc < i2cm_pkg::BITS_PER_BYTE) ? 3'd1 : 3'd3;
						end
						3'd3: begin
							chg_sda  = 1'b1;
							line_val = !nxt.ack_choice;
							nxt.step = 3'd4;
						end
						3'd4: begin chg_scl = 1'b1; line_val = 1'b1; nxt.step = 3'd5; end
						3'd5: begin chg_scl = 1'b1; line_val = 1'b0; nxt.step = 3'd6; end
						3'd6: begin chg_sda = 1'b1; line_val = 1'b0; nxt.step = 3'd7; end
						default: begin
							nxt.rx_byte = nxt.shift_byte;
							fin         = 1'b1;
						end
					endcase
				end
				default: fin = 1'b1;
			endcase
		end

		// every line change restarts the hold; an SCL release waits for the pin first
		if (chg_sda) begin
			nxt.sda        = line_val;
			nxt.wait_cnt   = hold;
			nxt.stretching = 1'b0;
		end
		if (chg_scl) begin
			nxt.scl        = line_val;
			nxt.wait_cnt   = hold;
			nxt.stretching = line_val;
		end
		if (fin) begin
			nxt.cmd        = i2cm_pkg::CMD_NONE;
			nxt.step       = 3'd0;
			nxt.bit_cnt    = 4'd0;
			nxt.wait_cnt   = 16'd0;
			nxt.stretching = 1'b0;
		end
	end

	always_comb begin
		res.scl_out      = nxt.scl;
		res.sda_out      = nxt.sda;
		res.busy_res     = (nxt.cmd != i2cm_pkg::CMD_NONE);
		res.done_res     = fin;
		res.rx_data      = nxt.rx_byte;
		res.ack_received = nxt.ack_flag;
		res.rejected     = rej;
	end

endmodule
